>>> rtl/b64d_pkg.sv
`default_nettype none

package b64d_pkg;

    localparam logic [7:0] PAD_CHAR = 8'd61;

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       message_end;
    } out_item_t;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } sextet_t;

    // Maps one character to its 6-bit value; valid is low outside the data alphabet.
    function automatic sextet_t sextet_lookup(input logic [7:0] c);
        sextet_t s;
        s.valid = 1'b1;
        s.value = 6'd0;
        if (c >= 8'd65 && c <= 8'd90) begin
            s.value = 6'(c - 8'd65);
        end
        else if (c >= 8'd97 && c <= 8'd122) begin
            s.value = 6'(c - 8'd71);
        end
        else if (c >= 8'd48 && c <= 8'd57) begin
            s.value = 6'(c + 8'd4);
        end
        else if (c == 8'd43) begin
            s.value = 6'd62;
        end
        else if (c == 8'd47) begin
            s.value = 6'd63;
        end
        else begin
            s.valid = 1'b0;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

>>> rtl/base64_stream_decoder.sv
// Streaming base64 decoder, one character per beat.
// The input channel (item_valid, item_ready, item) carries one character and a
// last flag per beat. The output channel (result_valid, result_ready, result)
// carries a decoded byte with its valid flag, and a message end flag.
// Characters outside the alphabet are dropped; an '=' stops decoding until the
// end of the message. The beat marked last always gives one result with
// message_end set, and the decoder then returns to the start of a group.
// A beat is taken into an input register; the lookup and byte assembly sit
// between that register and the result register, so a result is offered once
// its beat has moved from the input register into the result register.
// Throughput is one beat per cycle while the receiver keeps up: the input
// register advances whenever the result register is empty or drained that cycle.
// When the receiver stalls, the result register holds its beat and the input
// register holds one more; the input channel then stops taking beats.
// Reset clears both registers and the group state; no beat is lost or made.
`default_nettype none

module base64_stream_decoder (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_ready,
    input  wire b64d_pkg::in_item_t  item,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output b64d_pkg::out_item_t      result
);
    import b64d_pkg::*;

    logic      stage_valid_reg;
    in_item_t  stage_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t dec_result;
    logic      dec_produce;
    logic      out_free;
    logic      advance;

    b64d_group u_group (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (stage_item_reg),
        .advance (advance),
        .result  (dec_result),
        .produce (dec_produce)
    );

    assign out_free   = !out_valid_reg || result_ready;
    assign advance    = stage_valid_reg && (!dec_produce || out_free);
    assign item_ready = !stage_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stage_valid_reg <= 1'b0;
        end
        else if (item_ready) begin
            stage_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid) begin
            stage_item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free) begin
            out_valid_reg <= advance && dec_produce;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && advance && dec_produce) begin
            out_item_reg <= dec_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

endmodule

`default_nettype wire

>>> rtl/b64d_group.sv
`default_nettype none

module b64d_group (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire b64d_pkg::in_item_t item,
    input  wire logic               advance,
    output b64d_pkg::out_item_t     result,
    output logic                    produce
);
    import b64d_pkg::*;

    logic [1:0] pos_reg;
    logic [1:0] pos_next;
    logic [5:0] prev_reg;
    logic [5:0] prev_next;
    logic       pad_reg;
    logic       pad_next;
    sextet_t    lk;
    logic       is_pad;
    logic       take;
    logic       have;
    logic [7:0] byte_val;

    always_comb
    begin
        lk       = sextet_lookup(item.in_char);
        is_pad   = (item.in_char == PAD_CHAR);
        take     = lk.valid && !pad_reg;
        byte_val = 8'd0;
        case (pos_reg)
            2'd1:    byte_val = {prev_reg, lk.value[5:4]};
            2'd2:    byte_val = {prev_reg[3:0], lk.value[5:2]};
            2'd3:    byte_val = {prev_reg[1:0], lk.value};
            default: byte_val = 8'd0;
        endcase
        have = take && (pos_reg != 2'd0);

        produce            = have || item.in_last;
        result.out_byte    = have ? byte_val : 8'd0;
        result.byte_valid  = have;
        result.message_end = item.in_last;

        pos_next  = pos_reg;
        prev_next = prev_reg;
        pad_next  = pad_reg;
        if (item.in_last) begin
            pos_next  = 2'd0;
            prev_next = 6'd0;
            pad_next  = 1'b0;
        end
        else if (is_pad) begin
            pad_next = 1'b1;
        end
        else if (take) begin
            pos_next  = pos_reg + 2'd1;
            prev_next = lk.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg  <= 2'd0;
            prev_reg <= 6'd0;
            pad_reg  <= 1'b0;
        end
        else if (advance) begin
            pos_reg  <= pos_next;
            prev_reg <= prev_next;
            pad_reg  <= pad_next;
        end
    end

endmodule

`default_nettype wire
